@@ rtl/triangle_midpoint_terrain_assert.svh @@
// Assertion macros shared by the terrain generator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef TRIANGLE_MIDPOINT_TERRAIN_ASSERT_SVH
`define TRIANGLE_MIDPOINT_TERRAIN_ASSERT_SVH

// same-cycle implication
`define TMT_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("terrain assertion failed");

// next-cycle implication
`define TMT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("terrain assertion failed");

`endif

@@ rtl/tmt_pkg.sv @@
// Shared types and constants of the triangle midpoint terrain generator.
// Depends on nothing.
`default_nettype none

package tmt_pkg;

  localparam int IDX_W      = 9;
  localparam int LEVEL_W    = 4;
  localparam int AMP_W      = 20;
  localparam int DECAY_W    = 16;
  localparam int RAND_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int FRAC_SHIFT = 16;
  localparam int PROD_W     = RAND_W + AMP_W;
  localparam int DISP_W     = PROD_W - FRAC_SHIFT;
  localparam int QUARTER_W  = AMP_W - 2;
  localparam int JOB_DEPTH  = 4;
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam int LEVEL_RESET = 8;
  localparam logic [AMP_W-1:0]   INIT_AMP_RESET = 20'd160000;
  localparam logic [DECAY_W-1:0] DECAY_RESET    = 16'd36409;

  typedef enum logic [1:0] {
    PASS_X    = 2'd0,
    PASS_Y    = 2'd1,
    PASS_DIAG = 2'd2
  } pass_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_COUNT = 2'd0,
    REG_INIT_AMP    = 2'd1,
    REG_AMP_DECAY   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]     x_index;
    logic [IDX_W-1:0]     y_index;
    logic [DISP_W-1:0]    disp_hi;
    logic [QUARTER_W-1:0] quarter;
    logic                 corner_a;
    logic                 corner_b;
    logic                 level_start;
    logic                 last_point;
  } job_info_t;

  localparam int JOB_INFO_W = $bits(job_info_t);

endpackage

`default_nettype wire

@@ rtl/tmt_ram.sv @@
// Generic RAM: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module tmt_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 33153
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tmt_fifo.sv @@
// Small register FIFO with valid/ready on both sides and a fill count.
// Depends on nothing.
`default_nettype none

module tmt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [WIDTH-1:0]           in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [WIDTH-1:0]           out_data,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tmt_front.sv @@
// Front end: config registers, midpoint sequencer, endpoint addressing
// and displacement product. Depends on tmt_pkg.
`default_nettype none

module tmt_front #(
  parameter int MAX_LEVEL = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tmt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [tmt_pkg::RAND_W-1:0]        random_value,
  output logic                                   job_valid,
  input  wire logic                              job_ready,
  output tmt_pkg::job_info_t                     job_info,
  output logic [$clog2(((1 << MAX_LEVEL) + 1) *
                       ((1 << (MAX_LEVEL - 1)) + 1))-1:0] job_p,
  output logic [$clog2(((1 << MAX_LEVEL) + 1) *
                       ((1 << (MAX_LEVEL - 1)) + 1))-1:0] job_a,
  output logic [$clog2(((1 << MAX_LEVEL) + 1) *
                       ((1 << (MAX_LEVEL - 1)) + 1))-1:0] job_b
);

  localparam int POS_W  = MAX_LEVEL + 1;
  localparam int COLS   = (1 << (MAX_LEVEL - 1)) + 1;
  localparam int ROWS   = (1 << MAX_LEVEL) + 1;
  localparam int ADDR_W = $clog2(ROWS * COLS);
  localparam int LW     = tmt_pkg::LEVEL_W;
  localparam int LC_RST = (tmt_pkg::LEVEL_RESET > MAX_LEVEL) ? MAX_LEVEL
                                                             : tmt_pkg::LEVEL_RESET;
  localparam logic [POS_W-1:0] I_RST = POS_W'(1) << (LC_RST - 1);

  logic [LW-1:0]                 level_count;
  logic [tmt_pkg::AMP_W-1:0]     initial_amplitude;
  logic [tmt_pkg::DECAY_W-1:0]   amplitude_decay;
  logic [LW-1:0]                 level_now, level_now_next;
  tmt_pkg::pass_t                pass_now, pass_now_next;
  logic [POS_W-1:0]              outer_position, outer_position_next;
  logic [POS_W-1:0]              inner_position, inner_position_next;
  logic [tmt_pkg::AMP_W-1:0]     amplitude_now, amplitude_now_next;
  logic [tmt_pkg::AMP_W-1:0]     amp_scaled;
  logic                          last_next;

  logic [POS_W-1:0] span, half, ib, sk;
  logic [POS_W-1:0] px, py, ax1, ay1, ax2, ay2;
  logic [POS_W:0]   i_sum, o_sum;
  logic [LW-1:0]    level_inc;
  logic             accept;

  logic                          cfg_hit;
  logic [LW-1:0]                 lc_new;
  logic [tmt_pkg::AMP_W-1:0]     ia_new;
  logic [tmt_pkg::DECAY_W-1:0]   ad_new;
  logic [LW-1:0]                 lc_clamp;

  logic [tmt_pkg::PROD_W-1:0]                    disp_prod;
  logic [tmt_pkg::AMP_W+tmt_pkg::DECAY_W-1:0]    decay_prod;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [POS_W-1:0] ax,
                                                 input logic [POS_W-1:0] ay,
                                                 input logic [POS_W-1:0] m,
                                                 input logic [POS_W-1:0] h);
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    if (ay > h) begin
      row = m - ax;
      col = m + POS_W'(1) - ay;
    end else begin
      row = ax;
      col = ay;
    end
    return (ADDR_W'(row) << (MAX_LEVEL - 1)) + ADDR_W'(row) + ADDR_W'(col);
  endfunction

  function automatic logic is_corner(input logic [POS_W-1:0] ax,
                                     input logic [POS_W-1:0] ay,
                                     input logic [POS_W-1:0] m);
    return ((ay == '0) && ((ax == '0) || (ax == m))) || ((ax == m) && (ay == m));
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign accept    = in_valid && job_ready;

  assign span = POS_W'(1) << level_count;
  assign half = span >> 1;
  assign ib   = span >> ({1'b0, level_now} + 5'd1);
  assign sk   = ib << 1;

  // point and endpoints of the current midpoint
  always_comb begin
    case (pass_now)
      tmt_pkg::PASS_X: begin
        px  = inner_position;
        py  = outer_position;
        ax1 = inner_position - ib;
        ay1 = outer_position;
        ax2 = inner_position + ib;
        ay2 = outer_position;
      end
      tmt_pkg::PASS_Y: begin
        px  = outer_position;
        py  = inner_position;
        ax1 = outer_position;
        ay1 = inner_position + ib;
        ax2 = outer_position;
        ay2 = inner_position - ib;
      end
      default: begin
        px  = outer_position + inner_position;
        py  = inner_position;
        ax1 = outer_position + inner_position - ib;
        ay1 = inner_position - ib;
        ax2 = outer_position + inner_position + ib;
        ay2 = inner_position + ib;
      end
    endcase
  end

  assign disp_prod  = tmt_pkg::PROD_W'(random_value) * tmt_pkg::PROD_W'(amplitude_now);
  assign decay_prod = (tmt_pkg::AMP_W + tmt_pkg::DECAY_W)'(amplitude_now) *
                      (tmt_pkg::AMP_W + tmt_pkg::DECAY_W)'(amplitude_decay);

  always_comb begin
    job_info.x_index     = tmt_pkg::IDX_W'(px);
    job_info.y_index     = tmt_pkg::IDX_W'(py);
    job_info.disp_hi     = disp_prod[tmt_pkg::PROD_W-1:tmt_pkg::FRAC_SHIFT];
    job_info.quarter     = amplitude_now[tmt_pkg::AMP_W-1:2];
    job_info.corner_a    = is_corner(ax1, ay1, span);
    job_info.corner_b    = is_corner(ax2, ay2, span);
    job_info.level_start = (pass_now == tmt_pkg::PASS_X) &&
                           (outer_position == '0) && (inner_position == ib);
    job_info.last_point  = last_next;
    job_p = slot_of(px, py, span, half);
    job_a = slot_of(ax1, ay1, span, half);
    job_b = slot_of(ax2, ay2, span, half);
  end

  // sequencer advance
  always_comb begin
    i_sum               = {1'b0, inner_position} + {1'b0, sk};
    o_sum               = {1'b0, outer_position} + {1'b0, sk};
    level_inc           = level_now + LW'(1);
    level_now_next      = level_now;
    pass_now_next       = pass_now;
    outer_position_next = outer_position;
    inner_position_next = i_sum[POS_W-1:0];
    amplitude_now_next  = amplitude_now;
    last_next           = 1'b0;
    case (pass_now)
      tmt_pkg::PASS_X: begin
        if (i_sum > {1'b0, span}) begin
          if (o_sum >= {1'b0, span}) begin
            pass_now_next       = tmt_pkg::PASS_Y;
            outer_position_next = span;
            inner_position_next = ib;
          end else begin
            outer_position_next = o_sum[POS_W-1:0];
            inner_position_next = ib + o_sum[POS_W-1:0];
          end
        end
      end
      tmt_pkg::PASS_Y: begin
        if (i_sum > {1'b0, outer_position}) begin
          if (outer_position <= sk) begin
            pass_now_next       = tmt_pkg::PASS_DIAG;
            outer_position_next = '0;
            inner_position_next = ib;
          end else begin
            outer_position_next = outer_position - sk;
            inner_position_next = ib;
          end
        end
      end
      default: begin
        if (i_sum > {1'b0, span - outer_position}) begin
          if (o_sum >= {1'b0, span}) begin
            pass_now_next       = tmt_pkg::PASS_X;
            outer_position_next = '0;
            if (level_inc >= level_count) begin
              last_next           = 1'b1;
              level_now_next      = '0;
              inner_position_next = half;
              amplitude_now_next  = initial_amplitude;
            end else begin
              level_now_next      = level_inc;
              inner_position_next = span >> ({1'b0, level_inc} + 5'd1);
              amplitude_now_next  = amp_scaled;
            end
          end else begin
            outer_position_next = o_sum[POS_W-1:0];
            inner_position_next = ib;
          end
        end
      end
    endcase
  end

  // config decode
  always_comb begin
    lc_clamp = cfg_data[LW-1:0];
    if (lc_clamp == '0) begin
      lc_clamp = LW'(1);
    end else if (lc_clamp > LW'(MAX_LEVEL)) begin
      lc_clamp = LW'(MAX_LEVEL);
    end
    cfg_hit = cfg_valid;
    lc_new  = level_count;
    ia_new  = initial_amplitude;
    ad_new  = amplitude_decay;
    case (cfg_index)
      tmt_pkg::REG_LEVEL_COUNT: lc_new = lc_clamp;
      tmt_pkg::REG_INIT_AMP:    ia_new = cfg_data[tmt_pkg::AMP_W-1:0];
      tmt_pkg::REG_AMP_DECAY:   ad_new = cfg_data[tmt_pkg::DECAY_W-1:0];
      default:                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count       <= LW'(LC_RST);
      initial_amplitude <= tmt_pkg::INIT_AMP_RESET;
      amplitude_decay   <= tmt_pkg::DECAY_RESET;
      level_now         <= '0;
      pass_now          <= tmt_pkg::PASS_X;
      outer_position    <= '0;
      inner_position    <= I_RST;
      amplitude_now     <= tmt_pkg::INIT_AMP_RESET;
    end else if (cfg_hit) begin
      level_count       <= lc_new;
      initial_amplitude <= ia_new;
      amplitude_decay   <= ad_new;
      level_now         <= '0;
      pass_now          <= tmt_pkg::PASS_X;
      outer_position    <= '0;
      inner_position    <= POS_W'(1) << (lc_new - LW'(1));
      amplitude_now     <= ia_new;
    end else if (accept) begin
      level_now         <= level_now_next;
      pass_now          <= pass_now_next;
      outer_position    <= outer_position_next;
      inner_position    <= inner_position_next;
      amplitude_now     <= amplitude_now_next;
    end
  end

  // next-level amplitude, ready well before a level ends
  always_ff @(posedge clk) begin
    amp_scaled <= decay_prod[tmt_pkg::AMP_W+tmt_pkg::DECAY_W-1:tmt_pkg::FRAC_SHIFT];
  end

endmodule

`default_nettype wire

@@ rtl/tmt_back.sv @@
// Back end: endpoint reads, averaging, displacement, saturation and store
// write-back. Depends on tmt_pkg, tmt_ram and the assertion header.
`default_nettype none
`include "triangle_midpoint_terrain_assert.svh"

module tmt_back #(
  parameter int MAX_LEVEL   = 8,
  parameter int HEIGHT_BITS = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              job_valid,
  output logic                                   job_ready,
  input  wire tmt_pkg::job_info_t                job_info,
  input  wire logic [$clog2(((1 << MAX_LEVEL) + 1) *
                            ((1 << (MAX_LEVEL - 1)) + 1))-1:0] job_p,
  input  wire logic [$clog2(((1 << MAX_LEVEL) + 1) *
                            ((1 << (MAX_LEVEL - 1)) + 1))-1:0] job_a,
  input  wire logic [$clog2(((1 << MAX_LEVEL) + 1) *
                            ((1 << (MAX_LEVEL - 1)) + 1))-1:0] job_b,
  input  wire logic [tmt_pkg::OUT_CNT_W-1:0]     out_count,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output logic [2*tmt_pkg::IDX_W+HEIGHT_BITS:0]  res_data
);

  localparam int DEPTH  = ((1 << MAX_LEVEL) + 1) * ((1 << (MAX_LEVEL - 1)) + 1);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DISP_X = tmt_pkg::DISP_W + 2;
  localparam int SUM_W  = ((HEIGHT_BITS + 1 > DISP_X) ? HEIGHT_BITS + 1 : DISP_X) + 1;
  localparam logic signed [SUM_W-1:0] H_MAX =
    SUM_W'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] H_MIN = -H_MAX - SUM_W'(1);

  logic                        r_valid;
  tmt_pkg::job_info_t          r_info;
  logic [ADDR_W-1:0]           r_p;
  logic [ADDR_W-1:0]           r_b;
  logic                        c_valid;
  tmt_pkg::job_info_t          c_info;
  logic [ADDR_W-1:0]           c_p;
  logic [HEIGHT_BITS-1:0]      c_h1;

  logic                        pop;
  logic                        credit_ok;
  logic                        re;
  logic [ADDR_W-1:0]           raddr;
  logic [HEIGHT_BITS-1:0]      rdata;

  logic signed [HEIGHT_BITS-1:0] e1, e2;
  logic signed [HEIGHT_BITS:0]   end_sum, avg;
  logic signed [DISP_X-1:0]      disp;
  logic signed [SUM_W-1:0]       h_full;
  logic [HEIGHT_BITS-1:0]        h_sat;

  // room in the result queue for everything in flight plus this word
  assign credit_ok = c_valid ? (out_count < tmt_pkg::OUT_CNT_W'(tmt_pkg::OUT_DEPTH - 1))
                             : (out_count < tmt_pkg::OUT_CNT_W'(tmt_pkg::OUT_DEPTH));
  // first point of a level reads the previous level: let the last write land
  assign pop       = job_valid && !r_valid && credit_ok &&
                     (!job_info.level_start || !c_valid);
  assign job_ready = pop;
  assign re        = pop || r_valid;
  assign raddr     = r_valid ? r_b : job_a;

  tmt_ram #(
    .WIDTH(HEIGHT_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (c_valid),
    .waddr(c_p),
    .wdata(h_sat),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      r_valid <= pop;
      c_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_info <= job_info;
      r_p    <= job_p;
      r_b    <= job_b;
    end
    if (r_valid) begin
      c_info <= r_info;
      c_p    <= r_p;
      c_h1   <= rdata;
    end
  end

  always_comb begin
    e1      = c_info.corner_a ? '0 : $signed(c_h1);
    e2      = c_info.corner_b ? '0 : $signed(rdata);
    end_sum = (HEIGHT_BITS + 1)'(e1) + (HEIGHT_BITS + 1)'(e2);
    avg     = end_sum >>> 1;
    disp    = $signed({2'b00, c_info.disp_hi}) - $signed({3'b000, c_info.quarter});
    h_full  = SUM_W'(avg) + SUM_W'(disp);
    if (h_full > H_MAX) begin
      h_sat = HEIGHT_BITS'(H_MAX);
    end else if (h_full < H_MIN) begin
      h_sat = HEIGHT_BITS'(H_MIN);
    end else begin
      h_sat = HEIGHT_BITS'(h_full);
    end
  end

  assign res_valid = c_valid;
  assign res_data  = {c_info.x_index, c_info.y_index, h_sat, c_info.last_point};

  `TMT_ASSERT_NEXT(a_read_then_compute, clk, rst, r_valid, c_valid)
  `TMT_ASSERT_NEXT(a_two_cycle_issue, clk, rst, r_valid, !r_valid)
  `TMT_ASSERT_IMPLY(a_result_has_room, clk, rst, c_valid, res_ready)

endmodule

`default_nettype wire

@@ rtl/triangle_midpoint_terrain.sv @@
// Top level of the triangle midpoint-displacement terrain generator.
// Depends on tmt_pkg, tmt_front, tmt_fifo and tmt_back.
//
// Usage:
//   cfg_valid/cfg_ready write register cfg_index with cfg_data; ready is
//   always high. Index 0 level_count (clamped 1..MAX_LEVEL), 1 initial
//   amplitude, 2 Q16 amplitude decay. A write to index 0, 1 or 2 restarts the run.
//   in_valid/in_ready take one random word per midpoint; out_valid/out_ready
//   return one word per midpoint: x_index, y_index, saturated Q.4 height and
//   last_point on the final midpoint of a run. A new run follows at once.
//   The first point of each level waits for the previous write to the
//   store. The height store has a single read port (two endpoint reads per
//   midpoint), so the back end takes a new midpoint only once both reads of
//   the last one are issued.
//   A 4-word job queue and a 4-word result queue decouple both sides; when
//   out_ready stays low the result queue fills, then the job queue, then
//   in_ready drops. Reset returns registers to defaults and the run to the
//   first midpoint; the store is not cleared and corners read as zero.
`default_nettype none

module triangle_midpoint_terrain #(
  parameter int MAX_LEVEL   = 8,
  parameter int HEIGHT_BITS = 20
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tmt_pkg::RAND_W-1:0]     random_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tmt_pkg::IDX_W-1:0]           x_index,
  output logic [tmt_pkg::IDX_W-1:0]           y_index,
  output logic [HEIGHT_BITS-1:0]              height,
  output logic                                last_point
);

  localparam int ADDR_W = $clog2(((1 << MAX_LEVEL) + 1) * ((1 << (MAX_LEVEL - 1)) + 1));
  localparam int JOB_W  = tmt_pkg::JOB_INFO_W + 3 * ADDR_W;
  localparam int RES_W  = 2 * tmt_pkg::IDX_W + HEIGHT_BITS + 1;

  logic                        f_valid;
  logic                        f_ready;
  tmt_pkg::job_info_t          f_info;
  logic [ADDR_W-1:0]           f_p, f_a, f_b;

  logic                        q_valid;
  logic                        q_ready;
  logic [JOB_W-1:0]            q_data;
  tmt_pkg::job_info_t          q_info;
  logic [ADDR_W-1:0]           q_p, q_a, q_b;

  logic                        res_valid;
  logic                        res_ready;
  logic [RES_W-1:0]            res_data;
  logic [RES_W-1:0]            out_data;
  logic [tmt_pkg::OUT_CNT_W-1:0] out_count;

  tmt_front #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .random_value(random_value),
    .job_valid   (f_valid),
    .job_ready   (f_ready),
    .job_info    (f_info),
    .job_p       (f_p),
    .job_a       (f_a),
    .job_b       (f_b)
  );

  tmt_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(tmt_pkg::JOB_DEPTH)
  ) u_job_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_data  ({f_info, f_p, f_a, f_b}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data),
    .count    ()
  );

  assign {q_info, q_p, q_a, q_b} = q_data;

  tmt_back #(
    .MAX_LEVEL  (MAX_LEVEL),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(q_valid),
    .job_ready(q_ready),
    .job_info (q_info),
    .job_p    (q_p),
    .job_a    (q_a),
    .job_b    (q_b),
    .out_count(out_count),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  tmt_fifo #(
    .WIDTH(RES_W),
    .DEPTH(tmt_pkg::OUT_DEPTH)
  ) u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .in_data  (res_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .count    (out_count)
  );

  assign {x_index, y_index, height, last_point} = out_data;

endmodule

`default_nettype wire
